// File: design/lebuf_pkg.sv
package lebuf_pkg;

    localparam int LINE_DEPTH = 63;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    localparam logic [CHAR_W-1:0] CH_ERASE   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_KILL    = 8'h40;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_NEWLINE
    } lebuf_state_t;

    // controller -> datapath
    typedef struct packed {
        logic edit;
        logic start_flush;
        logic rd_issue;
        logic emit_char;
        logic emit_nl;
    } lebuf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_newline;
        logic pending;
        logic count_zero;
        logic idx_last;
        logic out_free;
    } lebuf_status_t;

endpackage

// File: design/lebuf_ctrl.sv
module lebuf_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    end_of_text,
    input  lebuf_pkg::lebuf_status_t status,
    output lebuf_pkg::lebuf_cmd_t   cmd,
    output logic                    in_stall
);

    lebuf_pkg::lebuf_state_t state_reg;
    lebuf_pkg::lebuf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lebuf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            lebuf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if ((end_of_text && status.pending) ||
                        (!end_of_text && status.is_newline))
                    begin
                        cmd.start_flush = 1'b1;
                        state_next = status.count_zero ? lebuf_pkg::ST_NEWLINE
                                                       : lebuf_pkg::ST_READ;
                    end
                    else if (!end_of_text)
                    begin
                        cmd.edit = 1'b1;
                    end
                end
            end
            lebuf_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = lebuf_pkg::ST_EMIT;
            end
            lebuf_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_char = 1'b1;
                    state_next = status.idx_last ? lebuf_pkg::ST_NEWLINE
                                                 : lebuf_pkg::ST_READ;
                end
            end
            lebuf_pkg::ST_NEWLINE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_nl = 1'b1;
                    state_next  = lebuf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lebuf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/lebuf_dp.sv
module lebuf_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lebuf_pkg::CHAR_W-1:0]      char_code,
    input  logic                              out_stall,
    input  lebuf_pkg::lebuf_cmd_t             cmd,
    output lebuf_pkg::lebuf_status_t          status,
    output logic                              out_valid,
    output logic [lebuf_pkg::CHAR_W-1:0]      out_char,
    output logic                              last
);

    logic [lebuf_pkg::CHAR_W-1:0] line_mem [lebuf_pkg::LINE_DEPTH];

    logic [lebuf_pkg::CNT_W-1:0]  fill_count_reg;
    logic [lebuf_pkg::CNT_W-1:0]  fill_count_next;
    logic                         pending_reg;
    logic                         pending_next;
    logic [lebuf_pkg::ADDR_W-1:0] rd_idx_reg;
    logic [lebuf_pkg::ADDR_W-1:0] rd_idx_next;
    logic [lebuf_pkg::CHAR_W-1:0] rd_data_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [lebuf_pkg::CHAR_W-1:0] out_char_reg;
    logic                         last_reg;
    logic                         mem_we;
    logic                         not_full;

    assign not_full = fill_count_reg < lebuf_pkg::CNT_W'(lebuf_pkg::LINE_DEPTH);

    always_comb
    begin
        fill_count_next = fill_count_reg;
        pending_next    = pending_reg;
        mem_we          = 1'b0;
        if (cmd.edit)
        begin
            pending_next = 1'b1;
            case (char_code)
                lebuf_pkg::CH_ERASE:
                begin
                    if (fill_count_reg != '0)
                    begin
                        fill_count_next = fill_count_reg - lebuf_pkg::CNT_W'(1);
                    end
                end
                lebuf_pkg::CH_KILL:
                begin
                    fill_count_next = '0;
                end
                default:
                begin
                    // full store: drop the character
                    if (not_full)
                    begin
                        mem_we          = 1'b1;
                        fill_count_next = fill_count_reg + lebuf_pkg::CNT_W'(1);
                    end
                end
            endcase
        end
        if (cmd.emit_nl)
        begin
            fill_count_next = '0;
            pending_next    = 1'b0;
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.start_flush)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.emit_char)
        begin
            rd_idx_next = rd_idx_reg + lebuf_pkg::ADDR_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_char || cmd.emit_nl)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            pending_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            pending_reg    <= pending_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[fill_count_reg[lebuf_pkg::ADDR_W-1:0]] <= char_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_data_reg <= line_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_char)
        begin
            out_char_reg <= rd_data_reg;
            last_reg     <= 1'b0;
        end
        else if (cmd.emit_nl)
        begin
            out_char_reg <= lebuf_pkg::CH_NEWLINE;
            last_reg     <= 1'b1;
        end
    end

    assign status.is_newline = char_code == lebuf_pkg::CH_NEWLINE;
    assign status.pending    = pending_reg;
    assign status.count_zero = fill_count_reg == '0;
    assign status.idx_last   = ({1'b0, rd_idx_reg} + (lebuf_pkg::ADDR_W + 1)'(1)) ==
                               (lebuf_pkg::ADDR_W + 1)'(fill_count_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

// File: design/line_edit_buffer_core.sv
// Line editor core. Characters come in one item per cycle on the input
// channel while no flush is under way, and build the current line in a
// 63-entry line store: '#' erases the newest stored character (no effect
// on an empty line), '@' kills the whole line, and any other byte is
// appended, or dropped once the store is full. A newline, or end_of_text
// while a line is pending, flushes the line: the stored characters come
// out oldest first with last = 0, followed by a newline (0x0A) with
// last = 1, and the store is cleared. end_of_text with nothing pending
// produces nothing. Editing characters never raise in_stall, so the next
// item is taken right away. A flush holds in_stall high throughout, and
// out_stall on the output stretches it: each stored character costs a
// registered read of the line store and then a load into the output
// register, and the closing newline is loaded last. The output register
// lets the next item enter while the final newline still waits to be taken.
module line_edit_buffer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lebuf_pkg::CHAR_W-1:0]  char_code,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lebuf_pkg::CHAR_W-1:0]  out_char,
    output logic                          last
);

    lebuf_pkg::lebuf_cmd_t    cmd;
    lebuf_pkg::lebuf_status_t status;

    // Sequencer: decodes accepted items and steps through a flush.
    lebuf_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .end_of_text (end_of_text),
        .status      (status),
        .cmd         (cmd),
        .in_stall    (in_stall)
    );

    // Line store, fill count, pending flag and output register.
    lebuf_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

// File: design/lebuf_checker.sv
module lebuf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [lebuf_pkg::CHAR_W-1:0]  char_code,
    input logic                          end_of_text,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [lebuf_pkg::CHAR_W-1:0]  out_char,
    input logic                          last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output item changed while stalled");

    // an editing item never produces a new result
    a_edit_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !end_of_text && char_code != lebuf_pkg::CH_NEWLINE
        |=> !out_valid || $past(out_valid && out_stall))
        else $error("result appeared after an editing item");

    // a newline always starts a flush
    a_nl_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !end_of_text && char_code == lebuf_pkg::CH_NEWLINE
        |=> in_stall)
        else $error("newline did not start a flush");

    // input reopens only once the closing newline is shown
    a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid && last && out_char == lebuf_pkg::CH_NEWLINE)
        else $error("flush ended without closing newline");

    // line characters appear only during a flush
    a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("line character shown while idle");

endmodule

bind line_edit_buffer_core lebuf_checker u_lebuf_checker (.*);

// File: tb/tb_line_edit_buffer_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the line editor core.
// Keystrokes are queued up front by the stimulus block and fed through the
// valid/stall input channel by a bursty driver. Every accepted keystroke is
// run through a local model of the editor (line store, fill count, pending
// flag). The model appends the characters that the flush should produce to
// a queue. A monitor pops that queue for each result taken off the output
// channel and compares it field by field. The receiver stalls in phases of
// different density, so that back pressure lands on every step of a flush.
module tb_line_edit_buffer_core;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 5;
    localparam int RAND_ITEMS  = 210;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [lebuf_pkg::CHAR_W-1:0] ch;
        logic                         eot;
    } keystroke_t;

    typedef struct {
        logic [lebuf_pkg::CHAR_W-1:0] ch;
        logic                         last;
    } line_char_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic [lebuf_pkg::CHAR_W-1:0] char_code   = '0;
    logic                         end_of_text = 1'b0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic [lebuf_pkg::CHAR_W-1:0] out_char;
    logic                         last;

    line_edit_buffer_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last        (last)
    );

    // Keystrokes waiting to be driven, and edited characters waiting to come out.
    keystroke_t keys_q[$];
    line_char_t emitted_q[$];

    // Local copy of the editor state.
    logic [lebuf_pkg::CHAR_W-1:0] line_chars [lebuf_pkg::LINE_DEPTH];
    int                           line_len  = 0;
    logic                         line_open = 1'b0;

    int   fail_count  = 0;
    int   cycle_count = 0;
    logic in_taken    = 1'b0;

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Editor model
    // ------------------------------------------------------------------

    // Emit the stored characters oldest first, close with a marked newline,
    // then clear the line.
    task automatic flush_line();
        for (int k = 0; k < line_len; k++)
            emitted_q.push_back('{ch: line_chars[k], last: 1'b0});
        emitted_q.push_back('{ch: lebuf_pkg::CH_NEWLINE, last: 1'b1});
        line_len  = 0;
        line_open = 1'b0;
    endtask

    task automatic apply_keystroke(input logic [lebuf_pkg::CHAR_W-1:0] ch,
                                   input logic eot);
        if (eot) begin
            // The character byte is ignored; flush only if something is pending.
            if (line_open)
                flush_line();
        end
        else if (ch == lebuf_pkg::CH_NEWLINE) begin
            flush_line();
        end
        else begin
            // Erase and kill mark the line pending even when they change nothing.
            line_open = 1'b1;
            if (ch == lebuf_pkg::CH_ERASE) begin
                if (line_len != 0)
                    line_len--;
            end
            else if (ch == lebuf_pkg::CH_KILL) begin
                line_len = 0;
            end
            else if (line_len < lebuf_pkg::LINE_DEPTH) begin
                line_chars[line_len] = ch;
                line_len++;
            end
            // A full store drops the character.
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_key(input logic [lebuf_pkg::CHAR_W-1:0] ch, input logic eot);
        keys_q.push_back('{ch: ch, eot: eot});
    endtask

    // Any byte that the editor stores as it is.
    function automatic logic [lebuf_pkg::CHAR_W-1:0] plain_char();
        logic [lebuf_pkg::CHAR_W-1:0] c;
        do
            c = lebuf_pkg::CHAR_W'($urandom_range(0, 255));
        while (c == lebuf_pkg::CH_NEWLINE || c == lebuf_pkg::CH_ERASE ||
               c == lebuf_pkg::CH_KILL);
        return c;
    endfunction

    // One line of random content: mostly plain characters with some edits
    // and a little noise, closed by a newline or by end of text.
    task automatic queue_random_line(input int target_len, inout int n_items);
        int pick;
        for (int i = 0; i < target_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 76)
                queue_key(plain_char(), 1'b0);
            else if (pick < 88)
                queue_key(lebuf_pkg::CH_ERASE, 1'b0);
            else if (pick < 93)
                queue_key(lebuf_pkg::CH_KILL, 1'b0);
            else
                // Noise: any byte, a newline here just ends the line early.
                queue_key(lebuf_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0);
            n_items++;
        end
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            queue_key(lebuf_pkg::CH_NEWLINE, 1'b0);
            n_items++;
        end
        else begin
            // End of text carries a random byte that must be ignored.
            queue_key(lebuf_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
            n_items++;
            // Sometimes a second one, with nothing pending.
            if (pick >= 92) begin
                queue_key(lebuf_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1);
                n_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed cases, random lines, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        int n_items;
        int target_len;

        // Directed cases.
        queue_key(lebuf_pkg::CH_NEWLINE, 1'b0);   // empty line: just the newline
        queue_key(8'hFF, 1'b1);                   // end of text, nothing pending
        queue_key(lebuf_pkg::CH_ERASE, 1'b0);     // erase on an empty line
        queue_key(lebuf_pkg::CH_NEWLINE, 1'b1);   // end of text flushes; byte ignored
        queue_key(8'h00, 1'b0);                   // extreme character values
        queue_key(8'hFF, 1'b0);
        queue_key(8'h61, 1'b0);
        queue_key(lebuf_pkg::CH_ERASE, 1'b0);     // erase the last stored one
        queue_key(8'h62, 1'b0);
        queue_key(lebuf_pkg::CH_NEWLINE, 1'b0);
        queue_key(8'h78, 1'b0);
        queue_key(8'h79, 1'b0);
        queue_key(lebuf_pkg::CH_KILL, 1'b0);      // kill the line so far
        queue_key(8'h7A, 1'b0);
        queue_key(lebuf_pkg::CH_NEWLINE, 1'b0);
        queue_key(8'h71, 1'b0);
        queue_key(8'h72, 1'b0);
        queue_key(8'h00, 1'b1);                   // end of text with a pending line
        queue_key(lebuf_pkg::CH_ERASE, 1'b1);     // then again with none pending
        queue_key(lebuf_pkg::CH_KILL, 1'b0);      // kill alone still marks pending
        queue_key(8'hA5, 1'b1);
        queue_key(8'h6B, 1'b0);
        queue_key(lebuf_pkg::CH_ERASE, 1'b0);
        queue_key(lebuf_pkg::CH_ERASE, 1'b0);     // erase past the start of the line
        queue_key(lebuf_pkg::CH_NEWLINE, 1'b0);

        // Random lines. The first overfills the store so that full-store drops
        // are always covered; later ones are mostly short with rare long ones.
        n_items = 0;
        for (int i = 0; i < lebuf_pkg::LINE_DEPTH + 4; i++) begin
            queue_key(plain_char(), 1'b0);
            n_items++;
        end
        queue_key(lebuf_pkg::CH_ERASE, 1'b0);
        queue_key(8'h5A, 1'b0);
        queue_key(lebuf_pkg::CH_NEWLINE, 1'b0);
        n_items += 3;
        while (n_items < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                target_len = $urandom_range(40, 70);
            else
                target_len = $urandom_range(0, 10);
            queue_random_line(target_len, n_items);
        end

        // Hold reset, then release it away from the rising edge.
        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the driver to run dry, then for every expected character.
        while (keys_q.size() != 0 || in_valid)
            @(posedge clk);
        while (emitted_q.size() != 0)
            @(posedge clk);
        // Leave room for any stray result.
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: bursts of items separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk) begin
        keystroke_t k;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken) begin
            // Advance only once the current item is gone.
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (keys_q.size() != 0) begin
                k = keys_q.pop_front();
                in_valid    <= 1'b1;
                char_code   <= k.ch;
                end_of_text <= k.eot;
                if (burst_left <= 1) begin
                    // Pick the next burst: now and then a long one with no gaps.
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 6);
                end
                else begin
                    burst_left--;
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall pattern: phases of free flow, light, heavy and long stalls
    // ------------------------------------------------------------------
    int stall_mode  = 0;
    int phase_left  = 0;
    int stall_run   = 0;
    logic run_state = 1'b0;

    always @(negedge clk) begin
        if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 80);
        end
        else begin
            phase_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                // Hold each level for a run of random length.
                if (stall_run == 0) begin
                    run_state = ~run_state;
                    stall_run = $urandom_range(1, 12);
                end
                else begin
                    stall_run--;
                end
                out_stall <= run_state;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Accept side and result monitor, both sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        line_char_t want;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end
        else begin
            in_taken <= in_valid && !in_stall;
            // Predict the results of each keystroke as the core takes it.
            if (in_valid && !in_stall)
                apply_keystroke(char_code, end_of_text);

            if (out_valid && !out_stall) begin
                if (emitted_q.size() == 0) begin
                    $error("unexpected result: out_char=%02h last=%0b", out_char, last);
                    fail_count++;
                end
                else begin
                    want = emitted_q.pop_front();
                    if (out_char !== want.ch) begin
                        $error("out_char: expected %02h, got %02h", want.ch, out_char);
                        fail_count++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Drop out if the run hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// File: filelist.f
design/lebuf_pkg.sv
design/lebuf_ctrl.sv
design/lebuf_dp.sv
design/line_edit_buffer_core.sv
design/lebuf_checker.sv
tb/tb_line_edit_buffer_core.sv
